// ----- rtl/olist_pkg.sv -----
`default_nettype none
package olist_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
    } res_t;

endpackage
`default_nettype wire

// ----- rtl/olist_mem.sv -----
`default_nettype none
module olist_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/olist_seq.sv -----
`default_nettype none
module olist_seq #(
    parameter int CAPACITY = 16,
    parameter int ADDR_W   = 4,
    parameter int CNT_W    = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [olist_pkg::OP_W-1:0]    op,
    input  wire logic [olist_pkg::VALUE_W-1:0] key,
    output logic                               mem_wr_en,
    output logic [ADDR_W-1:0]                  mem_wr_addr,
    output logic [olist_pkg::VALUE_W-1:0]      mem_wr_data,
    output logic                               mem_rd_en,
    output logic [ADDR_W-1:0]                  mem_rd_addr,
    input  wire logic [olist_pkg::VALUE_W-1:0] mem_rd_data,
    output logic                               res_valid,
    input  wire logic                          res_take,
    output olist_pkg::res_t                    res
);

    import olist_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    idx_reg,    idx_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [OP_W-1:0]     op_reg,     op_next;
    logic [VALUE_W-1:0]  key_reg,    key_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    // removed entry keeps its original index in the result
    logic [CNT_W-1:0]    pos_reg,    pos_next;

    logic [CNT_W:0]   idx_p1;
    logic [CNT_W:0]   idx_p2;
    logic [CNT_W:0]   count_ext;
    logic             more1;
    logic             more2;
    logic             hit;
    logic [CNT_W+4:0] cnt_wide;
    logic [CNT_W+3:0] pos_wide;

    assign idx_p1    = {1'b0, idx_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign idx_p2    = {1'b0, idx_reg} + (CNT_W+1)'(2);
    assign count_ext = {1'b0, count_reg};
    assign more1     = idx_p1 < count_ext;
    assign more2     = idx_p2 < count_ext;
    // single shared comparator for the scan
    assign hit       = mem_rd_data == key_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg[ADDR_W-1:0];
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_p1[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                mem_rd_addr = '0;
                if (in_valid)
                begin
                    op_next     = op;
                    key_next    = key;
                    idx_next    = '0;
                    pos_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    case (op)
                        OP_APPEND:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = count_reg[ADDR_W-1:0];
                                mem_wr_data = key;
                                idx_next    = count_reg;
                                pos_next    = count_reg;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        OP_SEARCH, OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_MISS;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // read data belongs to idx_reg; prefetch the next entry
                if (hit)
                begin
                    pos_next = idx_reg;
                    if (op_reg == OP_DELETE)
                    begin
                        if (more1)
                        begin
                            mem_rd_en  = 1'b1;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            state_next = S_RESP;
                        end
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (more1)
                begin
                    mem_rd_en = 1'b1;
                    idx_next  = idx_p1[CNT_W-1:0];
                end
                else
                begin
                    status_next = ST_MISS;
                    state_next  = S_RESP;
                end
            end
            S_SHIFT:
            begin
                // read data is entry idx+1, moved down into idx
                mem_wr_en   = 1'b1;
                mem_rd_addr = idx_p2[ADDR_W-1:0];
                if (more2)
                begin
                    mem_rd_en = 1'b1;
                    idx_next  = idx_p1[CNT_W-1:0];
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
    end

    assign in_stall  = state_reg != S_IDLE;
    assign res_valid = state_reg == S_RESP;
    assign cnt_wide  = {5'b0, count_reg};
    assign pos_wide  = {4'b0, pos_reg};

    always_comb
    begin
        res.status      = status_reg;
        res.position    = (status_reg == ST_OK) ? pos_wide[POS_W-1:0] : '0;
        res.entry_count = cnt_wide[COUNT_W-1:0];
    end

endmodule
`default_nettype wire

// ----- rtl/ordered_list_engine_core.sv -----
`default_nettype none
// Sequence: append, unused codes and search or delete on an empty list go from the request
// straight to the result state; search scans entries in order up to a match or the end,
// and delete then shifts each later entry down one place.
// Throughput: one request at a time; the next is taken once the result is in the output
// register. Scan and shift pace is set by the single read port of the entry RAM.
// Reset clears the entry count and the handshake state; entry RAM contents are not cleared.
module ordered_list_engine_core #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [olist_pkg::OP_W-1:0]      op,
    input  wire logic signed [olist_pkg::VALUE_W-1:0] value,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [olist_pkg::STATUS_W-1:0]       status,
    output logic [olist_pkg::POS_W-1:0]          position,
    output logic [olist_pkg::COUNT_W-1:0]        entry_count
);

    import olist_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [VALUE_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [VALUE_W-1:0] mem_rd_data;
    logic               res_valid;
    logic               res_take;
    res_t               res;
    res_t               out_reg;
    logic               out_valid_reg, out_valid_next;

    olist_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    olist_seq #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .key         ($unsigned(value)),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res)
    );

    // output register frees the sequencer as soon as it can be loaded
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign position    = out_reg.position;
    assign entry_count = out_reg.entry_count;

endmodule
`default_nettype wire

// ----- verif/ordered_list_engine_core_tb.sv -----
`timescale 1ns / 1ps

module ordered_list_engine_core_tb;
    import olist_pkg::*;

    localparam int CAP         = CAPACITY_DEFAULT;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [VALUE_W-1:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] KEY_ZERO = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] KEY_ONES = 32'hFFFF_FFFF;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [OP_W-1:0]            op;
    logic signed [VALUE_W-1:0]  value;
    logic                       out_valid;
    logic                       out_stall;
    logic [STATUS_W-1:0]        status;
    logic [POS_W-1:0]           position;
    logic [COUNT_W-1:0]         entry_count;

    // shadow of the list held by the block
    logic [VALUE_W-1:0] list_mem [CAP];
    int                 list_len;
    res_t               expected_results [$];

    int error_count;
    int quiet_cycles;
    int idle_odds;
    int stall_odds;

    ordered_list_engine_core #(
        .CAPACITY    (CAP)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .position    (position),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic res_t apply_list_op(input logic [OP_W-1:0] code,
                                           input logic [VALUE_W-1:0] key);
        res_t r;
        int   hit;
        r.status   = ST_OK;
        r.position = '0;
        hit        = -1;
        case (code)
            OP_APPEND:
            begin
                if (list_len >= CAP)
                    r.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = key;
                    r.position         = POS_W'(list_len);
                    list_len++;
                end
            end
            OP_SEARCH, OP_DELETE:
            begin
                for (int i = 0; i < list_len; i++)
                    if (hit < 0 && list_mem[i] == key)
                        hit = i;
                if (hit < 0)
                    r.status = ST_MISS;
                else
                begin
                    r.position = POS_W'(hit);
                    if (code == OP_DELETE)
                    begin
                        for (int i = hit; i < list_len - 1; i++)
                            list_mem[i] = list_mem[i + 1];
                        list_len--;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = COUNT_W'(list_len);
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] pool_key(input int idx);
        case (idx)
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return KEY_ZERO;
            3:       return KEY_ONES;
            4:       return 32'h0000_0001;
            5:       return 32'h5555_AAAA;
            6:       return 32'hAAAA_5555;
            default: return 32'h0000_002A;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // accepted request: predict its result
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            expected_results.push_back(apply_list_op(op, value));
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no request pending, status", status, -1);
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (position !== want.position)
                    report_mismatch("position", position, want.position);
                if (entry_count !== want.entry_count)
                    report_mismatch("entry_count", entry_count, want.entry_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result side back-pressure in bursts
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_odds > 0 && $urandom_range(1, stall_odds) == 1)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
        end
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input logic [OP_W-1:0] code, input logic [VALUE_W-1:0] key);
        int gap;
        gap = 0;
        if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1)
            gap = $urandom_range(1, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        value    <= key;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        idle_odds  = 3;
        stall_odds = 3;
        // empty list: misses and the unused code
        send_request(OP_SEARCH, 32'h0000_0005);
        send_request(OP_DELETE, KEY_MAX);
        send_request(OP_UNUSED, KEY_ZERO);
        send_request(OP_APPEND, KEY_MIN);
        send_request(OP_APPEND, KEY_MAX);
        send_request(OP_APPEND, KEY_ZERO);
        send_request(OP_APPEND, KEY_ONES);
        send_request(OP_APPEND, KEY_MAX);
        // duplicate: first match wins
        send_request(OP_SEARCH, KEY_MAX);
        send_request(OP_DELETE, KEY_MAX);
        send_request(OP_SEARCH, KEY_MAX);
        send_request(OP_SEARCH, 32'h1234_5678);
        send_request(OP_DELETE, KEY_MIN);
        send_request(OP_DELETE, KEY_ONES);
        send_request(OP_UNUSED, KEY_ONES);
        send_request(OP_SEARCH, KEY_ZERO);
    endtask

    task automatic test_full_list();
        int                 room;
        logic [VALUE_W-1:0] head;
        logic [VALUE_W-1:0] tail_key;
        idle_odds  = 4;
        stall_odds = 4;
        // let everything settle so the shadow list is stable
        wait_drained();
        room     = CAP - list_len;
        head     = list_mem[0];
        tail_key = {16'hA5A5, 16'(room - 1)};
        for (int k = 0; k < room + 2; k++)
            send_request(OP_APPEND, {16'hA5A5, 16'(k)});
        send_request(OP_SEARCH, tail_key);
        send_request(OP_DELETE, tail_key);
        send_request(OP_DELETE, head);
        send_request(OP_SEARCH, tail_key);
    endtask

    task automatic test_random(input int n_items, input bit calm);
        bit                 grow;
        int                 pick;
        logic [OP_W-1:0]    code;
        logic [VALUE_W-1:0] key;
        grow = 1'b0;
        if (calm)
        begin
            idle_odds  = 0;
            stall_odds = 0;
        end
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 50 == 0)
                grow = ~grow;
            if (!calm && k % 200 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_odds = 0;
                    1:       idle_odds = 2;
                    default: idle_odds = 5;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 2;
                    default: stall_odds = 6;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (grow)
                code = (pick < 55) ? OP_APPEND : (pick < 75) ? OP_SEARCH :
                       (pick < 97) ? OP_DELETE : OP_UNUSED;
            else
                code = (pick < 25) ? OP_APPEND : (pick < 50) ? OP_SEARCH :
                       (pick < 95) ? OP_DELETE : OP_UNUSED;
            // mostly a small set of keys so searches and deletes hit
            if ($urandom_range(0, 9) < 6)
                key = pool_key($urandom_range(0, 7));
            else
                key = $urandom;
            send_request(code, key);
        end
    endtask

    initial
    begin
        in_valid     = 1'b0;
        op           = OP_APPEND;
        value        = '0;
        rst_n        = 1'b0;
        list_len     = 0;
        error_count  = 0;
        quiet_cycles = 0;
        idle_odds    = 0;
        stall_odds   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_list();
        test_random(1700, 1'b0);
        test_random(300, 1'b1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
